>>> hw/rtl/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int TIME_BITS  = 16;
    localparam int SLOT_BITS  = $clog2(MAX_PROCS);
    localparam int COUNT_BITS = $clog2(MAX_PROCS + 1);

    localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] SLOTS_ALL = COUNT_BITS'(MAX_PROCS);

    // request function codes
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // one process table entry
    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] remaining;
        logic [TIME_BITS-1:0] prio;
        logic [TIME_BITS-1:0] start;
    } t_entry;

    // one result
    typedef struct packed {
        logic                 ran_valid;
        logic [SLOT_BITS-1:0] ran_slot;
        logic                 finished;
        logic [TIME_BITS-1:0] wait_time;
        logic [TIME_BITS-1:0] turnaround_time;
        logic [TIME_BITS-1:0] response_time;
        logic                 all_done;
        logic                 table_full;
    } t_result;

    // sequencer status toward the top level
    typedef struct packed {
        logic                  busy;
        logic [COUNT_BITS-1:0] loaded;
        logic [COUNT_BITS-1:0] finished;
    } t_status;

    // subtract, clamped at zero
    function automatic logic [TIME_BITS-1:0] sat_sub(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

>>> hw/rtl/pps_table.sv
`timescale 1ns / 1ps

module pps_table import pps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [SLOT_BITS-1:0] i_wr_addr,
    input  t_entry               i_wr_data,
    input  logic                 i_rd_en,
    input  logic [SLOT_BITS-1:0] i_rd_addr,
    output t_entry               o_rd_data
);

    t_entry r_mem [MAX_PROCS];
    t_entry r_rd_data;

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/pps_ctrl.sv
`timescale 1ns / 1ps

module pps_ctrl import pps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_func,
    input  logic [TIME_BITS-1:0] i_arrival_time,
    input  logic [TIME_BITS-1:0] i_burst_time,
    input  logic [TIME_BITS-1:0] i_priority_level,
    input  logic                 i_res_take,
    output logic                 o_res_valid,
    output t_result              o_res,
    output t_status              o_status,
    output logic                 o_wr_en,
    output logic [SLOT_BITS-1:0] o_wr_addr,
    output t_entry               o_wr_data,
    output logic                 o_rd_en,
    output logic [SLOT_BITS-1:0] o_rd_addr,
    input  t_entry               i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_RESULT
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_loaded, n_loaded;
    logic [COUNT_BITS-1:0] r_finished, n_finished;
    logic [TIME_BITS-1:0]  r_tick, n_tick;
    logic [COUNT_BITS-1:0] r_issue, n_issue;
    logic                  r_cmp_valid, n_cmp_valid;
    logic [SLOT_BITS-1:0]  r_cmp_idx, n_cmp_idx;
    logic                  r_found, n_found;
    logic [SLOT_BITS-1:0]  r_best_idx, n_best_idx;
    t_entry                r_best, n_best;
    logic [TIME_BITS-1:0]  r_done, n_done;
    t_result               r_res, n_res;

    logic [TIME_BITS-1:0]  tick_inc;
    logic                  cand_ready;
    logic                  cand_better;
    t_entry                upd;

    assign tick_inc    = (r_tick == TIME_MAX) ? r_tick : r_tick + 1'b1;
    assign cand_ready  = (i_rd_data.arrival <= r_tick) && (i_rd_data.remaining != '0);
    assign cand_better = !r_found || (i_rd_data.prio < r_best.prio);

    // run the chosen process for one tick
    always_comb begin
        upd           = r_best;
        upd.remaining = r_best.remaining - 1'b1;
        if (r_best.remaining == r_best.burst) begin
            upd.start = r_tick;
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_finished  = r_finished;
        n_tick      = r_tick;
        n_issue     = r_issue;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_done      = r_done;
        n_res       = r_res;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_best_idx;
        o_wr_data   = upd;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_issue[SLOT_BITS-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = S_RESULT;
                    case (t_func'(i_func))
                        FUNC_LOAD: begin
                            if (r_loaded == SLOTS_ALL) begin
                                n_res.table_full = 1'b1;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_loaded[SLOT_BITS-1:0];
                                o_wr_data.arrival = i_arrival_time;
                                o_wr_data.burst   = (i_burst_time == '0) ?
                                                    TIME_BITS'(1) : i_burst_time;
                                o_wr_data.remaining = o_wr_data.burst;
                                o_wr_data.prio    = i_priority_level;
                                o_wr_data.start   = '0;
                                n_loaded  = r_loaded + 1'b1;
                            end
                        end
                        FUNC_TICK: begin
                            if (r_loaded == '0) begin
                                n_tick = tick_inc;
                            end else begin
                                n_issue     = '0;
                                n_cmp_valid = 1'b0;
                                n_found     = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_loaded   = '0;
                            n_finished = '0;
                            n_tick     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // compare the entry read last cycle against the best so far
                if (r_cmp_valid && cand_ready && cand_better) begin
                    n_found    = 1'b1;
                    n_best     = i_rd_data;
                    n_best_idx = r_cmp_idx;
                end
                // issue the next slot read, or finish once the last compare is done
                if (r_issue < r_loaded) begin
                    o_rd_en     = 1'b1;
                    n_issue     = r_issue + 1'b1;
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_issue[SLOT_BITS-1:0];
                end else begin
                    n_cmp_valid = 1'b0;
                    if (r_cmp_valid) begin
                        n_state = S_FIN1;
                    end
                end
            end

            S_FIN1: begin
                n_tick  = tick_inc;
                n_state = S_RESULT;
                if (r_found) begin
                    o_wr_en           = 1'b1;
                    n_best            = upd;
                    n_done            = tick_inc;
                    n_res.ran_valid   = 1'b1;
                    n_res.ran_slot    = r_best_idx;
                    if (upd.remaining == '0) begin
                        n_res.finished      = 1'b1;
                        n_finished          = r_finished + 1'b1;
                        n_res.response_time = sat_sub(upd.start, upd.arrival);
                        n_state             = S_FIN2;
                    end
                end
            end

            S_FIN2: begin
                n_res.turnaround_time = sat_sub(r_done, r_best.arrival);
                n_state               = S_FIN3;
            end

            S_FIN3: begin
                n_res.wait_time = sat_sub(r_res.turnaround_time, r_best.burst);
                n_state         = S_RESULT;
            end

            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state, counters and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_finished  <= '0;
            r_tick      <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_finished  <= n_finished;
            r_tick      <= n_tick;
            r_cmp_valid <= n_cmp_valid;
            r_found     <= n_found;
        end
        r_issue    <= n_issue;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_done     <= n_done;
        r_res      <= n_res;
    end

    // present result with the current completion flag
    always_comb begin
        o_res          = r_res;
        o_res.all_done = (r_finished == r_loaded);
    end

    assign o_res_valid       = (r_state == S_RESULT);
    assign o_status.busy     = (r_state != S_IDLE);
    assign o_status.loaded   = r_loaded;
    assign o_status.finished = r_finished;

endmodule

>>> hw/rtl/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_func, i_arrival_time, i_burst_time,
//                                               i_priority_level
// out      output     o_out_valid / i_out_stall o_ran_valid, o_ran_slot, o_finished,
//                                               o_wait_time, o_turnaround_time,
//                                               o_response_time, o_all_done, o_table_full
//
// Load, clear and unknown requests, and a tick on an empty table, go straight to the
// result; a tick on a loaded table scans the loaded slots, and when the chosen process
// finishes it also computes the turnaround and then the wait time. The tick length is set
// by the slot scan: one table read and one priority compare per cycle through the single
// table read port and the shared compare unit.
// Synchronous active-low reset empties the table and zeroes time; no clearing pass.
// A stalled output holds one result; the next request is accepted meanwhile and its
// result waits in the sequencer until the output register frees.

module preemptive_priority_scheduler import pps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [TIME_BITS-1:0] i_arrival_time,
    input  logic [TIME_BITS-1:0] i_burst_time,
    input  logic [TIME_BITS-1:0] i_priority_level,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_ran_valid,
    output logic [SLOT_BITS-1:0] o_ran_slot,
    output logic                 o_finished,
    output logic [TIME_BITS-1:0] o_wait_time,
    output logic [TIME_BITS-1:0] o_turnaround_time,
    output logic [TIME_BITS-1:0] o_response_time,
    output logic                 o_all_done,
    output logic                 o_table_full
);

    logic                 res_valid;
    logic                 res_take;
    t_result              res;
    t_status              status;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    t_entry               wr_data;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    t_entry               rd_data;
    logic                 r_out_valid;
    t_result              r_out;

    pps_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pps_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_func           (i_func),
        .i_arrival_time   (i_arrival_time),
        .i_burst_time     (i_burst_time),
        .i_priority_level (i_priority_level),
        .i_res_take       (res_take),
        .o_res_valid      (res_valid),
        .o_res            (res),
        .o_status         (status),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data)
    );

    assign o_in_stall = status.busy;
    assign res_take   = !r_out_valid || !i_out_stall;

    // output register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ran_valid       = r_out.ran_valid;
    assign o_ran_slot        = r_out.ran_slot;
    assign o_finished        = r_out.finished;
    assign o_wait_time       = r_out.wait_time;
    assign o_turnaround_time = r_out.turnaround_time;
    assign o_response_time   = r_out.response_time;
    assign o_all_done        = r_out.all_done;
    assign o_table_full      = r_out.table_full;

`ifndef SYNTHESIS
    // an accepted request always leaves the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after request accept");

    // never more finished processes than loaded ones
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.finished <= status.loaded)
        else $error("finished count exceeds loaded count");

    // a completion is only reported for a process that ran
    a_finish_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> o_ran_valid)
        else $error("finish reported without a running process");
`endif

endmodule
